// ----- hdl/tr90_pkg.sv -----
// Shared types, constants and helper functions for the quarter-turn glyph tile.
// Every other file in the block imports this package; it depends on nothing.
package tr90_pkg;

  // Tile geometry.
  localparam int MAX_DIM    = 32;
  localparam int IDX_W      = 5;
  localparam int DIM_W      = 6;
  localparam int CELL_COUNT = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int GLYPH_W    = 2;

  // Command codes.
  localparam logic [1:0] OP_WRITE     = 2'd0;
  localparam logic [1:0] OP_ROT_LEFT  = 2'd1;
  localparam logic [1:0] OP_ROT_RIGHT = 2'd2;
  localparam logic [1:0] OP_READ      = 2'd3;

  // Glyph codes.
  localparam logic [GLYPH_W-1:0] GLYPH_PLUS = 2'd0;
  localparam logic [GLYPH_W-1:0] GLYPH_DASH = 2'd1;
  localparam logic [GLYPH_W-1:0] GLYPH_BAR  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_LOADED_ROWS = 1'b0;
  localparam logic CFG_LOADED_COLS = 1'b1;

  typedef struct packed {
    logic [1:0]         op;
    logic [IDX_W-1:0]   row_index;
    logic [IDX_W-1:0]   col_index;
    logic [GLYPH_W-1:0] glyph_in;
  } cmd_t;

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph_out;
    logic [DIM_W-1:0]   current_rows;
    logic [DIM_W-1:0]   current_cols;
    logic               bad_index;
  } result_t;

  // Read position mapped back to the loaded frame.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              bad;
    logic              odd;
    logic [DIM_W-1:0]  rows;
    logic [DIM_W-1:0]  cols;
  } map_t;

  // Limit a size register value to 1..MAX_DIM.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end
    return res;
  endfunction

  // A quarter turn trades dash and bar.
  function automatic logic [GLYPH_W-1:0] swap_glyph(input logic [GLYPH_W-1:0] g);
    logic [GLYPH_W-1:0] res;
    res = g;
    if (g == GLYPH_DASH) begin
      res = GLYPH_BAR;
    end else if (g == GLYPH_BAR) begin
      res = GLYPH_DASH;
    end
    return res;
  endfunction

endpackage

// ----- hdl/tile_rotate_90.sv -----
// Quarter-turn glyph tile: a command is taken in every cycle (busy is low but in reset).
// A read gives its result in the cycle after its transfer, strobed by done for one cycle;
// writes and rotations give none. Latency is set by the registered read of the cell RAM.
// Synchronous reset clears the turn count, the sizes (to 1 by 1) and the result strobe;
// the cell RAM is not cleared and holds whatever was last written.
module tile_rotate_90
  import tr90_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  cmd_t             cmd,
  output logic             done,
  output result_t          result,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [DIM_W-1:0] cfg_data
);

  logic [DIM_W-1:0]   loaded_rows;
  logic [DIM_W-1:0]   loaded_cols;
  logic [1:0]         turns;
  logic [1:0]         turns_next;
  logic               take;
  logic               wr_ok;
  logic               rd_go;
  map_t               map;
  logic [GLYPH_W-1:0] cell_q;
  logic               rd_bad;
  logic               rd_odd;
  logic [DIM_W-1:0]   rd_rows;
  logic [DIM_W-1:0]   rd_cols;

  assign busy = rst;
  assign take = start && !busy;

  // Configuration writes, clamped to the legal size range.
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_rows <= DIM_W'(1);
      loaded_cols <= DIM_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == CFG_LOADED_ROWS) begin
        loaded_rows <= clamp_dim(cfg_data);
      end else begin
        loaded_cols <= clamp_dim(cfg_data);
      end
    end
  end

  // A write is kept only inside the loaded size and with a legal glyph.
  assign wr_ok = take && (cmd.op == OP_WRITE)
                 && (DIM_W'(cmd.row_index) < loaded_rows)
                 && (DIM_W'(cmd.col_index) < loaded_cols)
                 && (cmd.glyph_in <= GLYPH_BAR);
  assign rd_go = take && (cmd.op == OP_READ);

  // Turn count update.
  always_comb begin
    turns_next = turns;
    if (take) begin
      case (cmd.op)
        OP_WRITE:     turns_next = wr_ok ? 2'd0 : turns;
        OP_ROT_LEFT:  turns_next = turns - 2'd1;
        OP_ROT_RIGHT: turns_next = turns + 2'd1;
        default:      turns_next = turns;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      turns <= 2'd0;
    end else begin
      turns <= turns_next;
    end
  end

  tr90_frame_map u_map (
    .turns       (turns),
    .loaded_rows (loaded_rows),
    .loaded_cols (loaded_cols),
    .row_index   (cmd.row_index),
    .col_index   (cmd.col_index),
    .map         (map)
  );

  tr90_cell_mem u_mem (
    .clk   (clk),
    .we    (wr_ok),
    .waddr ({cmd.row_index, cmd.col_index}),
    .wdata (cmd.glyph_in),
    .re    (rd_go),
    .raddr (map.addr),
    .rdata (cell_q)
  );

  // Read strobe alongside the RAM access.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rd_go;
    end
  end

  // Side information of a read, carried while the RAM access completes.
  always_ff @(posedge clk) begin
    if (rd_go) begin
      rd_bad  <= map.bad;
      rd_odd  <= map.odd;
      rd_rows <= map.rows;
      rd_cols <= map.cols;
    end
  end

  // Result assembly from the RAM data.
  always_comb begin
    result.current_rows = rd_rows;
    result.current_cols = rd_cols;
    result.bad_index    = rd_bad;
    if (rd_bad) begin
      result.glyph_out = GLYPH_PLUS;
    end else if (rd_odd) begin
      result.glyph_out = swap_glyph(cell_q);
    end else begin
      result.glyph_out = cell_q;
    end
  end

endmodule

// ----- hdl/tr90_cell_mem.sv -----
// Cell store of the tile: one synchronous RAM, one write and one read port.
// Depends on tr90_pkg for the depth and the glyph width.
module tr90_cell_mem
  import tr90_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [GLYPH_W-1:0] wdata,
  input  logic               re,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [GLYPH_W-1:0] rdata
);

  logic [GLYPH_W-1:0] mem [CELL_COUNT];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/tr90_frame_map.sv -----
// Maps a current-frame read position back to the loaded frame and checks range.
// Depends on tr90_pkg for the widths and the map_t result struct.
module tr90_frame_map
  import tr90_pkg::*;
(
  input  logic [1:0]       turns,
  input  logic [DIM_W-1:0] loaded_rows,
  input  logic [DIM_W-1:0] loaded_cols,
  input  logic [IDX_W-1:0] row_index,
  input  logic [IDX_W-1:0] col_index,
  output map_t             map
);

  logic [DIM_W-1:0] r_ext;
  logic [DIM_W-1:0] c_ext;
  logic [DIM_W-1:0] sr;
  logic [DIM_W-1:0] sc;

  // Size in the current orientation, the range check, and the position in the
  // loaded frame for each of the four orientations.
  always_comb begin
    r_ext    = DIM_W'(row_index);
    c_ext    = DIM_W'(col_index);
    map.odd  = turns[0];
    map.rows = turns[0] ? loaded_cols : loaded_rows;
    map.cols = turns[0] ? loaded_rows : loaded_cols;
    map.bad  = (r_ext >= map.rows) || (c_ext >= map.cols);
    case (turns)
      2'd0: begin
        sr = r_ext;
        sc = c_ext;
      end
      2'd1: begin
        sr = loaded_rows - DIM_W'(1) - c_ext;
        sc = r_ext;
      end
      2'd2: begin
        sr = loaded_rows - DIM_W'(1) - r_ext;
        sc = loaded_cols - DIM_W'(1) - c_ext;
      end
      default: begin
        sr = c_ext;
        sc = loaded_cols - DIM_W'(1) - r_ext;
      end
    endcase
    map.addr = {sr[IDX_W-1:0], sc[IDX_W-1:0]};
  end

endmodule
